// ----- design/ajc_pkg.sv -----
package ajc_pkg;

	localparam int POS_W      = 32;
	localparam int VEL_W      = 12;
	localparam int CNT_W      = 8;
	localparam int DIV_W      = 9;
	localparam int LVL_W      = 4;
	localparam int OP_W       = 2;
	localparam int AXIS_W     = 2;
	localparam int MODE_W     = 3;
	localparam int KIND_W     = 2;
	localparam int SPD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int ITER_W     = $clog2(POS_W + 1);

	localparam int NUM_AXES_DEF = 3;

	localparam logic [OP_W-1:0] OP_JOG   = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_CYCLE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POS  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VEL  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNIT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FINE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COARSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DIV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 2'd2;

	localparam logic [CNT_W-1:0] HOLD_THR_RST = 8'd10;
	localparam logic [DIV_W-1:0] GRID_DIV_RST = 9'd1;
	localparam logic [LVL_W-1:0] LEVEL_RST    = 4'd7;

	localparam logic [LVL_W-1:0] LEVEL_SNAP_MIN = 4'd7;
	localparam logic [DIV_W-1:0] GRID_FINE      = 9'd50;
	localparam logic [DIV_W-1:0] GRID_COARSE    = 9'd500;

	localparam logic [ITER_W-1:0] ITER_GRID = ITER_W'(DIV_W);
	localparam logic [ITER_W-1:0] ITER_MAG  = ITER_W'(POS_W);

	typedef struct packed {
		logic                     start;
		logic signed [POS_W-1:0]  pos;
		logic signed [POS_W-1:0]  origin;
		logic [MODE_W-1:0]        mode;
	} snap_req_t;

	typedef struct packed {
		logic                     done;
		logic [POS_W-1:0]         target;
	} snap_rsp_t;

	function automatic logic [POS_W-1:0] step_size(input logic [SPD_W-1:0] sp);
		logic [POS_W-1:0] r;
		case (sp)
			2'd0:    r = POS_W'(1);
			2'd1:    r = POS_W'(50);
			2'd2:    r = POS_W'(100);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [VEL_W-1:0] vel_size(input logic [SPD_W-1:0] sp);
		logic [VEL_W-1:0] r;
		case (sp)
			2'd0:    r = VEL_W'(3);
			2'd1:    r = VEL_W'(1024);
			2'd2:    r = VEL_W'(2047);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/ajc_serdiv.sv -----
module ajc_serdiv #(
	parameter int DW = ajc_pkg::POS_W,
	parameter int VW = ajc_pkg::DIV_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DW-1:0]                 dividend,
	input  logic [VW-1:0]                 divisor,
	input  logic [$clog2(DW+1)-1:0]       iters,
	output logic                          done,
	output logic [DW-1:0]                 quotient,
	output logic [VW-1:0]                 remainder
);
	import ajc_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;

	logic [VW:0]   trial;
	logic [VW:0]   trial_sub;
	logic          ge;
	logic [VW-1:0] rem_n;

	// One quotient bit per cycle, most significant first.
	assign trial     = {rem_q, dvd_q[DW-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = trial >= {1'b0, dvs_q};
	assign rem_n     = ge ? trial_sub[VW-1:0] : trial[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= iters;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- design/ajc_snap.sv -----
module ajc_snap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ajc_pkg::snap_req_t           req,
	input  logic [ajc_pkg::DIV_W-1:0]    grid_divisor,
	input  logic [ajc_pkg::LVL_W-1:0]    machine_level,
	output ajc_pkg::snap_rsp_t           rsp
);
	import ajc_pkg::*;

	typedef enum logic [3:0] {
		SN_IDLE = 4'b0001,
		SN_QUOT = 4'b0010,
		SN_REM  = 4'b0100,
		SN_FIX  = 4'b1000
	} snap_state_t;

	snap_state_t      st_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W:0]   d_q;
	logic             nosnap_q;
	logic [DIV_W-1:0] s_q;
	logic [DIV_W-1:0] rem_q;

	logic              grid_req;
	logic              div_start;
	logic [POS_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic [ITER_W-1:0] div_iters;
	logic              div_done;
	logic [POS_W-1:0]  div_quot;
	logic [DIV_W-1:0]  div_rem;
	logic [DIV_W-1:0]  grid_n;
	logic [POS_W:0]    d_neg;
	logic [DIV_W-1:0]  quot_s;
	logic [DIV_W-1:0]  adj;

	assign grid_req = (machine_level >= LEVEL_SNAP_MIN) && (grid_divisor != '0)
		&& ((req.mode == MODE_FINE) || (req.mode == MODE_COARSE));
	assign grid_n   = (req.mode == MODE_FINE) ? GRID_FINE : GRID_COARSE;
	assign d_neg    = (POS_W+1)'(0) - d_q;
	assign quot_s   = div_quot[DIV_W-1:0];

	always_comb begin
		div_start    = 1'b0;
		div_dividend = {grid_n, (POS_W-DIV_W)'(0)};
		div_divisor  = grid_divisor;
		div_iters    = ITER_GRID;
		if (st_q == SN_IDLE) begin
			div_start = req.start && grid_req;
		end else if (st_q == SN_QUOT) begin
			div_start    = div_done && (quot_s != '0);
			div_dividend = d_q[POS_W] ? d_neg[POS_W-1:0] : d_q[POS_W-1:0];
			div_divisor  = quot_s;
			div_iters    = ITER_MAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SN_IDLE;
		end else begin
			unique case (st_q)
				SN_IDLE: begin
					if (req.start) begin
						st_q <= grid_req ? SN_QUOT : SN_FIX;
					end
				end
				SN_QUOT: begin
					if (div_done) begin
						st_q <= (quot_s != '0) ? SN_REM : SN_FIX;
					end
				end
				SN_REM: begin
					if (div_done) begin
						st_q <= SN_FIX;
					end
				end
				SN_FIX: begin
					st_q <= SN_IDLE;
				end
				default: begin
					st_q <= SN_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == SN_IDLE && req.start) begin
			pos_q    <= req.pos;
			d_q      <= {req.pos[POS_W-1], req.pos} - {req.origin[POS_W-1], req.origin};
			nosnap_q <= !grid_req;
		end
		if (st_q == SN_QUOT && div_done) begin
			s_q      <= quot_s;
			nosnap_q <= (quot_s == '0);
		end
		if (st_q == SN_REM && div_done) begin
			rem_q <= div_rem;
		end
	end

	// The adjustment is applied in the direction of the sign of the offset from the jog start.
	assign adj = s_q - rem_q;

	always_comb begin
		rsp.done   = (st_q == SN_FIX);
		rsp.target = pos_q;
		if (!nosnap_q && rem_q != '0) begin
			rsp.target = d_q[POS_W] ? pos_q - POS_W'(adj) : pos_q + POS_W'(adj);
		end
	end

	ajc_serdiv #(
		.DW(POS_W),
		.VW(DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.iters     (div_iters),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

endmodule

// ----- design/axis_jog_controller.sv -----
// Jog, speed-cycle and ignored requests: the result is registered in the pending stage, then in the output stage.
// Stop request: without grid snapping the snap unit passes the position straight through;
// with it, the bit-serial divider finds the grid step and, if nonzero, the offset remainder.
// A new request is taken in the cycle after a result leaves the internal stage.
// Asynchronous active-low reset clears press counts, jog starts, locks, speed step
// and loads the configuration defaults (threshold 10, divisor 1, level 7).
module axis_jog_controller #(
	parameter int NUM_AXES = ajc_pkg::NUM_AXES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ajc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ajc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ajc_pkg::OP_W-1:0]           op,
	input  logic [ajc_pkg::AXIS_W-1:0]         axis,
	input  logic                               direction,
	input  logic signed [ajc_pkg::POS_W-1:0]   position,
	input  logic [ajc_pkg::MODE_W-1:0]         stop_mode,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ajc_pkg::KIND_W-1:0]         command_kind,
	output logic [ajc_pkg::AXIS_W-1:0]         command_axis,
	output logic signed [ajc_pkg::POS_W-1:0]   target_position,
	output logic signed [ajc_pkg::VEL_W-1:0]   velocity,
	output logic                               axis_locked
);
	import ajc_pkg::*;

	localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int KW  = (NUM_AXES > 1) ? $clog2(2 * NUM_AXES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SNAP = 2'b10
	} top_state_t;

	top_state_t        st_q;
	logic [CNT_W-1:0]  thr_q;
	logic [DIV_W-1:0]  div_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [SPD_W-1:0]  speed_q;
	logic [CNT_W-1:0]  press_q [2*NUM_AXES];
	logic [POS_W-1:0]  start_q [NUM_AXES];
	logic              lock_q  [NUM_AXES];
	logic [AXIS_W-1:0] stop_axis_q;

	logic              pend_valid_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [AXIS_W-1:0] pend_axis_q;
	logic [POS_W-1:0]  pend_tgt_q;
	logic [VEL_W-1:0]  pend_vel_q;
	logic              pend_lock_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [AXIS_W-1:0] out_axis_q;
	logic [POS_W-1:0]  out_tgt_q;
	logic [VEL_W-1:0]  out_vel_q;
	logic              out_lock_q;

	logic              acc;
	logic              axis_ok;
	logic              is_jog;
	logic              is_stop;
	logic              is_cycle;
	logic [AXW-1:0]    idx;
	logic [KW-1:0]     key;
	logic [KW-1:0]     other;
	logic [CNT_W-1:0]  cnt;
	logic              cnt_zero;
	logic              cnt_hit;
	logic              cnt_below;
	logic [POS_W-1:0]  step;
	logic [VEL_W-1:0]  vmag;
	logic [KIND_W-1:0] jog_kind;
	logic [POS_W-1:0]  jog_tgt;
	logic [VEL_W-1:0]  jog_vel;
	logic              move;

	snap_req_t         snap_req;
	snap_rsp_t         snap_rsp;

	assign in_ready = (st_q == ST_IDLE) && !pend_valid_q;
	assign acc      = in_valid && in_ready;
	assign axis_ok  = (AXIS_W+2)'(axis) < (AXIS_W+2)'(NUM_AXES);
	assign is_jog   = acc && (op == OP_JOG) && axis_ok;
	assign is_stop  = acc && (op == OP_STOP) && axis_ok;
	assign is_cycle = acc && (op == OP_CYCLE);

	assign idx   = AXW'(axis);
	assign key   = KW'({idx, direction});
	assign other = KW'({idx, !direction});

	assign cnt       = press_q[key];
	assign cnt_zero  = (cnt == '0);
	assign cnt_hit   = (cnt == thr_q);
	assign cnt_below = (cnt < thr_q);
	assign step      = step_size(speed_q);
	assign vmag      = vel_size(speed_q);

	// A velocity command at the hold threshold overrides the first-press step.
	always_comb begin
		jog_kind = KIND_NONE;
		jog_tgt  = '0;
		jog_vel  = '0;
		if (cnt_hit) begin
			jog_kind = KIND_VEL;
			jog_vel  = direction ? VEL_W'(0) - vmag : vmag;
		end else if (cnt_zero) begin
			jog_kind = KIND_POS;
			jog_tgt  = direction ? $unsigned(position) - step : $unsigned(position) + step;
		end
	end

	assign snap_req.start  = is_stop;
	assign snap_req.pos    = position;
	assign snap_req.origin = start_q[idx];
	assign snap_req.mode   = stop_mode;

	assign move = pend_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			thr_q        <= HOLD_THR_RST;
			div_q        <= GRID_DIV_RST;
			lvl_q        <= LEVEL_RST;
			speed_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 2 * NUM_AXES; i++) begin
				press_q[i] <= '0;
			end
			for (int i = 0; i < NUM_AXES; i++) begin
				start_q[i] <= '0;
				lock_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HOLD_THR: thr_q <= cfg_data[CNT_W-1:0];
					REG_GRID_DIV: div_q <= cfg_data[DIV_W-1:0];
					REG_LEVEL:    lvl_q <= cfg_data[LVL_W-1:0];
					default: begin
					end
				endcase
			end

			if (is_cycle) begin
				speed_q <= (speed_q >= SPD_W'(2)) ? '0 : speed_q + SPD_W'(1);
				for (int i = 0; i < 2 * NUM_AXES; i++) begin
					press_q[i] <= '0;
				end
			end

			if (is_jog) begin
				lock_q[idx] <= 1'b0;
				if (cnt_zero) begin
					press_q[other] <= '0;
					start_q[idx]   <= $unsigned(position);
				end
				if (cnt_below) begin
					press_q[key] <= cnt + CNT_W'(1);
				end
			end

			if (is_stop) begin
				press_q[KW'({idx, 1'b0})] <= '0;
				press_q[KW'({idx, 1'b1})] <= '0;
				lock_q[idx]               <= 1'b1;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (is_stop) begin
						st_q <= ST_SNAP;
					end
				end
				ST_SNAP: begin
					if (snap_rsp.done) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if ((acc && !is_stop) || snap_rsp.done) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_stop) begin
			stop_axis_q <= axis;
		end
		if (acc && !is_stop) begin
			pend_kind_q <= is_jog ? jog_kind : KIND_NONE;
			pend_axis_q <= is_jog ? axis : '0;
			pend_tgt_q  <= is_jog ? jog_tgt : '0;
			pend_vel_q  <= is_jog ? jog_vel : '0;
			pend_lock_q <= 1'b0;
		end else if (snap_rsp.done) begin
			pend_kind_q <= KIND_POS;
			pend_axis_q <= stop_axis_q;
			pend_tgt_q  <= snap_rsp.target;
			pend_vel_q  <= '0;
			pend_lock_q <= lock_q[AXW'(stop_axis_q)];
		end
		if (move) begin
			out_kind_q <= pend_kind_q;
			out_axis_q <= pend_axis_q;
			out_tgt_q  <= pend_tgt_q;
			out_vel_q  <= pend_vel_q;
			out_lock_q <= pend_lock_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign command_kind    = out_kind_q;
	assign command_axis    = out_axis_q;
	assign target_position = $signed(out_tgt_q);
	assign velocity        = $signed(out_vel_q);
	assign axis_locked     = out_lock_q;

	ajc_snap u_snap (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (snap_req),
		.grid_divisor  (div_q),
		.machine_level (lvl_q),
		.rsp           (snap_rsp)
	);

	a_snap_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		snap_rsp.done |-> (st_q == ST_SNAP))
		else $error("snap result arrived while no stop request was waiting");

	a_stop_starts_snap: assert property (@(posedge clk) disable iff (!arst_n)
		is_stop |=> (st_q == ST_SNAP) && !in_ready)
		else $error("stop request did not start the snap sequence");

	a_pending_kept: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && out_valid_q && !out_ready |=> pend_valid_q)
		else $error("pending result dropped while output stalled");

	a_velocity_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command_kind == KIND_VEL) && (speed_q != SPD_W'(3))
		|-> (velocity != '0))
		else $error("velocity command with zero magnitude");

endmodule

// ----- sim/tb_axis_jog_controller.sv -----
`timescale 1ns / 1ps

module tb_axis_jog_controller;
	import ajc_pkg::*;

	localparam int NUM_AXES = NUM_AXES_DEF;
	localparam int LIMIT = 400000;
	localparam int PHASE_EVENTS = 70;

	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [AXIS_W-1:0]    AXIS_BAD   = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic                 DIR_POS    = 1'b0;
	localparam logic                 DIR_NEG    = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [AXIS_W-1:0]        axis;
		logic                     dir;
		logic signed [POS_W-1:0]  pos;
		logic [MODE_W-1:0]        mode;
	} key_event_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [AXIS_W-1:0]  cax;
		logic [POS_W-1:0]   tgt;
		logic [VEL_W-1:0]   vel;
		logic               lck;
	} jog_cmd_t;

	typedef struct packed {
		logic                   is_reg;
		logic [CFG_IDX_W-1:0]   ridx;
		logic [CFG_DATA_W-1:0]  rdata;
		key_event_t             ev;
		logic                   typed;
		jog_cmd_t               want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [OP_W-1:0] op;
	logic [AXIS_W-1:0] axis;
	logic direction;
	logic signed [POS_W-1:0] position;
	logic [MODE_W-1:0] stop_mode;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] command_kind;
	logic [AXIS_W-1:0] command_axis;
	logic signed [POS_W-1:0] target_position;
	logic signed [VEL_W-1:0] velocity;
	logic axis_locked;

	axis_jog_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.axis(axis),
		.direction(direction),
		.position(position),
		.stop_mode(stop_mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command_kind(command_kind),
		.command_axis(command_axis),
		.target_position(target_position),
		.velocity(velocity),
		.axis_locked(axis_locked)
	);

	always #2 clk = ~clk;

	logic [CNT_W-1:0] hold_thr = HOLD_THR_RST;
	logic [DIV_W-1:0] grid_div = GRID_DIV_RST;
	logic [LVL_W-1:0] level = LEVEL_RST;
	logic [1:0] speed = 2'd0;
	logic [CNT_W-1:0] presses [2*NUM_AXES];
	logic signed [POS_W-1:0] jog_origin [NUM_AXES];
	logic locks [NUM_AXES];

	jog_cmd_t cmds_due [$];
	int fails = 0;
	int events_done = 0;
	int cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_hold = 0;

	int phase_thr [9] = '{10, 1, 3, 511, 5, 0, 2, 4, 7};
	int phase_div [9] = '{1, 500, 7, 1, 13, 0, 511, 25, 3};
	int phase_lvl [9] = '{7, 15, 0, 6, 7, 8, 9, 7, 12};

	function automatic jog_cmd_t apply_event(input key_event_t e);
		jog_cmd_t res;
		int k;
		longint p, stp, spd_v, d, s, rem, t;
		logic [MODE_W-1:0] m;
		res = '0;
		p = $signed(e.pos);
		case (speed)
			2'd0: begin
				stp = 1;
				spd_v = 3;
			end
			2'd1: begin
				stp = 50;
				spd_v = 1024;
			end
			default: begin
				stp = 100;
				spd_v = 2047;
			end
		endcase
		if (e.op == OP_CYCLE) begin
			speed = (speed >= 2'd2) ? 2'd0 : speed + 2'd1;
			for (int i = 0; i < 2*NUM_AXES; i++) presses[i] = '0;
		end else if (e.op != OP_UNUSED && e.axis < NUM_AXES) begin
			res.cax = e.axis;
			if (e.op == OP_JOG) begin
				k = e.axis * 2 + e.dir;
				locks[e.axis] = 1'b0;
				if (presses[k] == 0) begin
					presses[k ^ 1] = '0;
					jog_origin[e.axis] = e.pos;
					res.kind = KIND_POS;
					t = e.dir ? p - stp : p + stp;
					res.tgt = t[POS_W-1:0];
				end
				if (presses[k] == hold_thr) begin
					res.kind = KIND_VEL;
					res.tgt = '0;
					t = e.dir ? -spd_v : spd_v;
					res.vel = t[VEL_W-1:0];
				end
				if (presses[k] < hold_thr) presses[k] = presses[k] + 1'b1;
			end else begin
				t = p;
				if (e.mode != MODE_HOLD) begin
					s = 0;
					m = (level < LEVEL_SNAP_MIN) ? MODE_NONE : e.mode;
					if (m == MODE_UNIT) s = 1;
					else if (m == MODE_FINE && grid_div != 0) s = 50 / longint'(grid_div);
					else if (m == MODE_COARSE && grid_div != 0) s = 500 / longint'(grid_div);
					if (s > 0) begin
						d = p - longint'(jog_origin[e.axis]);
						rem = d % s;
						if (rem > 0) t = p + s - rem;
						else if (rem < 0) t = p - s - rem;
					end
				end
				presses[e.axis * 2] = '0;
				presses[e.axis * 2 + 1] = '0;
				locks[e.axis] = 1'b1;
				res.kind = KIND_POS;
				res.tgt = t[POS_W-1:0];
			end
			res.lck = locks[e.axis];
		end
		return res;
	endfunction

	function automatic plan_row_t key(input logic [OP_W-1:0] o, input logic [AXIS_W-1:0] a,
			input logic d, input logic signed [POS_W-1:0] p, input logic [MODE_W-1:0] md);
		plan_row_t r;
		r = '0;
		r.ev = '{o, a, d, p, md};
		return r;
	endfunction

	function automatic plan_row_t key_is(input logic [OP_W-1:0] o, input logic [AXIS_W-1:0] a,
			input logic d, input logic signed [POS_W-1:0] p, input logic [MODE_W-1:0] md,
			input logic [KIND_W-1:0] kd, input logic [AXIS_W-1:0] ca,
			input logic [POS_W-1:0] tg, input logic [VEL_W-1:0] vl, input logic lk);
		plan_row_t r;
		r = key(o, a, d, p, md);
		r.typed = 1'b1;
		r.want = '{kd, ca, tg, vl, lk};
		return r;
	endfunction

	function automatic plan_row_t reg_set(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.ridx = idx;
		r.rdata = val;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (tx_calm || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic signed [POS_W-1:0] pick_pos();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return int'($urandom_range(0, 10000)) - 5000;
		if (roll < 80) return $urandom;
		if (roll < 90) return 32'h7FFF_FFFF - $urandom_range(0, 150);
		return 32'h8000_0000 + $urandom_range(0, 150);
	endfunction

	task automatic send(input key_event_t e, input bit typed, input jog_cmd_t want);
		int gap;
		jog_cmd_t got;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= e.op;
		axis <= e.axis;
		direction <= e.dir;
		position <= e.pos;
		stop_mode <= e.mode;
		do @(posedge clk); while (!in_ready);
		got = apply_event(e);
		cmds_due.push_back(typed ? want : got);
		if (e.op == OP_CYCLE || (e.op != OP_UNUSED && e.axis < NUM_AXES)) events_done++;
		if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (cmds_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HOLD_THR: hold_thr = val[CNT_W-1:0];
			REG_GRID_DIV: grid_div = val[DIV_W-1:0];
			REG_LEVEL:    level = val[LVL_W-1:0];
			default:      ;
		endcase
	endtask

	task automatic run_sequence();
		int roll, n, lim, a;
		logic d;
		logic signed [POS_W-1:0] base;
		key_event_t e;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			e.op = OP_W'($urandom);
			e.axis = AXIS_W'($urandom);
			e.dir = 1'($urandom);
			e.pos = $urandom;
			e.mode = MODE_W'($urandom);
			send(e, 1'b0, '0);
		end else if (roll < 15) begin
			e = '{OP_CYCLE, AXIS_W'($urandom), 1'($urandom), $urandom, MODE_W'($urandom)};
			send(e, 1'b0, '0);
		end else begin
			a = $urandom_range(0, NUM_AXES - 1);
			d = 1'($urandom);
			base = pick_pos();
			lim = int'(hold_thr) + 3;
			if (lim > 14) lim = 14;
			n = $urandom_range(1, lim);
			for (int i = 0; i < n; i++) begin
				e.op = OP_JOG;
				e.axis = AXIS_W'(a);
				e.dir = (roll < 22 && i == n / 2) ? ~d : d;
				e.pos = (i == 0) ? base : base + $urandom_range(0, 255);
				e.mode = MODE_W'($urandom);
				send(e, 1'b0, '0);
			end
			if ($urandom_range(0, 99) < 85) begin
				e.op = OP_STOP;
				e.axis = AXIS_W'(a);
				e.dir = 1'($urandom);
				if ($urandom_range(0, 9) < 8) e.mode = MODE_W'($urandom_range(1, 4));
				else e.mode = MODE_W'($urandom);
				if ($urandom_range(0, 3) == 0) e.pos = pick_pos();
				else e.pos = base + (int'($urandom_range(0, 2000)) - 1000);
				send(e, 1'b0, '0);
			end
		end
	endtask

	task automatic check_field(input string what, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] seen);
		if (seen !== want) begin
			fails++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
		end
	endtask

	always @(posedge clk) begin
		jog_cmd_t w;
		if (arst_n && out_valid && out_ready) begin
			if (cmds_due.size() == 0) begin
				fails++;
				$display("%0t: command expected none, got kind %0h", $time, command_kind);
			end else begin
				w = cmds_due.pop_front();
				check_field("command_kind", POS_W'(w.kind), POS_W'(command_kind));
				check_field("command_axis", POS_W'(w.cax), POS_W'(command_axis));
				check_field("target_position", w.tgt, $unsigned(target_position));
				check_field("velocity", POS_W'(w.vel), POS_W'($unsigned(velocity)));
				check_field("axis_locked", POS_W'(w.lck), POS_W'(axis_locked));
			end
		end
	end

	always @(posedge clk) begin
		int roll;
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= 1'b1;
			roll = $urandom_range(0, 99);
			if (!rx_calm && roll < 25) begin
				if (roll < 20) rx_hold = $urandom_range(1, 3);
				else rx_hold = $urandom_range(8, 40);
			end
		end
		if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		int phase_end;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= OP_JOG;
		axis <= '0;
		direction <= DIR_POS;
		position <= '0;
		stop_mode <= MODE_NONE;
		for (int i = 0; i < 2*NUM_AXES; i++) presses[i] = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			jog_origin[i] = '0;
			locks[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			key_is(OP_JOG, 2'd0, DIR_POS, 32'sd0, MODE_NONE, KIND_POS, 2'd0, 32'd1, 12'd0, 1'b0),
			key_is(OP_JOG, 2'd1, DIR_POS, 32'h7FFF_FFFF, MODE_NONE,
				KIND_POS, 2'd1, 32'h8000_0000, 12'd0, 1'b0),
			key_is(OP_JOG, 2'd1, DIR_NEG, 32'h8000_0000, MODE_NONE,
				KIND_POS, 2'd1, 32'h7FFF_FFFF, 12'd0, 1'b0),
			key_is(OP_STOP, 2'd1, DIR_POS, 32'sd1234, MODE_HOLD,
				KIND_POS, 2'd1, 32'd1234, 12'd0, 1'b1),
			key_is(OP_STOP, 2'd2, DIR_NEG, -32'sd5, MODE_NONE,
				KIND_POS, 2'd2, 32'hFFFF_FFFB, 12'd0, 1'b1),
			key_is(OP_JOG, AXIS_BAD, DIR_NEG, -32'sd1, MODE_SPARE,
				KIND_NONE, 2'd0, 32'd0, 12'd0, 1'b0),
			key_is(OP_UNUSED, 2'd1, DIR_NEG, -32'sd1, MODE_SPARE,
				KIND_NONE, 2'd0, 32'd0, 12'd0, 1'b0),
			key_is(OP_CYCLE, 2'd2, DIR_NEG, 32'sd77, MODE_COARSE,
				KIND_NONE, 2'd0, 32'd0, 12'd0, 1'b0),
			key_is(OP_JOG, 2'd2, DIR_POS, 32'sd100, MODE_NONE, KIND_POS, 2'd2, 32'd150, 12'd0, 1'b0),
			key(OP_STOP, 2'd2, DIR_POS, 32'sd107, MODE_UNIT),
			key(OP_JOG, 2'd2, DIR_NEG, 32'sd1000, MODE_NONE),
			key(OP_STOP, 2'd2, DIR_NEG, 32'sd1013, MODE_FINE),
			key(OP_JOG, 2'd2, DIR_NEG, 32'sd1000, MODE_NONE),
			key(OP_STOP, 2'd2, DIR_POS, 32'sd987, MODE_COARSE),
			key(OP_JOG, 2'd0, DIR_NEG, 32'h7FFF_FF00, MODE_NONE),
			key(OP_STOP, 2'd0, DIR_NEG, 32'h7FFF_FFFF, MODE_COARSE),
			key(OP_STOP, 2'd0, DIR_POS, 32'sd4321, MODE_SPARE),
			key(OP_CYCLE, 2'd0, DIR_POS, 32'sd0, MODE_NONE),
			key_is(OP_JOG, 2'd0, DIR_POS, -32'sd1, MODE_NONE, KIND_POS, 2'd0, 32'd99, 12'd0, 1'b0),
			reg_set(REG_HOLD_THR, 9'd1),
			key_is(OP_JOG, 2'd0, DIR_POS, 32'sd3, MODE_NONE, KIND_VEL, 2'd0, 32'd0, 12'h7FF, 1'b0),
			key_is(OP_JOG, 2'd0, DIR_NEG, 32'sd3, MODE_NONE,
				KIND_POS, 2'd0, 32'hFFFF_FF9F, 12'd0, 1'b0),
			key_is(OP_JOG, 2'd0, DIR_NEG, 32'sd3, MODE_NONE, KIND_VEL, 2'd0, 32'd0, 12'h801, 1'b0),
			reg_set(REG_HOLD_THR, 9'd0),
			key_is(OP_JOG, 2'd1, DIR_POS, 32'sd40, MODE_NONE, KIND_VEL, 2'd1, 32'd0, 12'h7FF, 1'b0),
			reg_set(REG_GRID_DIV, 9'd0),
			reg_set(REG_LEVEL, 9'd15),
			key_is(OP_STOP, 2'd1, DIR_POS, 32'sd12345, MODE_FINE,
				KIND_POS, 2'd1, 32'd12345, 12'd0, 1'b1),
			reg_set(REG_GRID_DIV, 9'd511),
			key_is(OP_STOP, 2'd1, DIR_POS, 32'sd777, MODE_COARSE,
				KIND_POS, 2'd1, 32'd777, 12'd0, 1'b1),
			reg_set(REG_GRID_DIV, 9'd1),
			reg_set(REG_LEVEL, 9'd6),
			key_is(OP_STOP, 2'd1, DIR_POS, 32'sd3, MODE_FINE, KIND_POS, 2'd1, 32'd3, 12'd0, 1'b1),
			reg_set(REG_UNUSED, 9'h1AA),
			reg_set(REG_HOLD_THR, 9'd10),
			reg_set(REG_LEVEL, 9'd7),
			key(OP_JOG, 2'd2, DIR_POS, 32'sd10, MODE_NONE),
			key(OP_JOG, 2'd2, DIR_POS, 32'sd11, MODE_NONE),
			key(OP_JOG, 2'd2, DIR_POS, 32'sd12, MODE_NONE),
			reg_set(REG_HOLD_THR, 9'd2),
			key_is(OP_JOG, 2'd2, DIR_POS, 32'sd0, MODE_NONE, KIND_NONE, 2'd2, 32'd0, 12'd0, 1'b0)
		};

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].ridx, plan[i].rdata);
			end else begin
				send(plan[i].ev, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 9; ph++) begin
			settle();
			write_reg(REG_HOLD_THR, CFG_DATA_W'(phase_thr[ph]));
			write_reg(REG_GRID_DIV, CFG_DATA_W'(phase_div[ph]));
			write_reg(REG_LEVEL, CFG_DATA_W'(phase_lvl[ph]));
			phase_end = events_done + PHASE_EVENTS;
			while (events_done < phase_end) run_sequence();
		end

		in_valid <= 1'b0;
		while (cmds_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
